@@ design/uled_pkg.sv @@
// Shared types, constants and the control store of the line editor.
// Holds the microcode table and the error message text; no dependencies.
`timescale 1ns / 1ps

package uled_pkg;

  localparam logic [1:0] KIND_RX     = 2'd0;
  localparam logic [1:0] KIND_TAKE   = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;
  localparam logic [1:0] KIND_QUERY  = 2'd3;

  localparam logic [1:0] RK_TX       = 2'd0;
  localparam logic [1:0] RK_LINE     = 2'd1;
  localparam logic [1:0] RK_STATUS   = 2'd2;

  localparam logic [7:0] CH_DELETE   = 8'h7f;
  localparam logic [7:0] CH_NEWLINE  = 8'h0a;
  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_SP       = 8'h20;
  localparam logic [7:0] CH_LOW_A    = 8'h61;
  localparam logic [7:0] CH_LOW_Z    = 8'h7a;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  localparam logic [4:0] MSG_LEN     = 5'd31;
  localparam logic [8*31-1:0] MSG_TEXT = "The input character is invalid.";

  typedef enum logic [3:0] {
    U_IDLE, U_ERR, U_DEL0, U_DEL1, U_DEL2, U_NL, U_CHR,
    U_TAKE0, U_TAKE1, U_TAKE2, U_CLR, U_QRY
  } upc_t;

  typedef enum logic [2:0] {
    A_NONE, A_DEL, A_NL, A_STORE, A_REWIND, A_READ, A_CLR_RDY
  } act_t;

  typedef enum logic [2:0] {
    S_ZERO, S_MSG, S_BS, S_SP, S_CH, S_MEM
  } src_t;

  typedef enum logic [1:0] {
    G_ALWAYS, G_FILL_NZ, G_ROOM, G_CNT_LEFT
  } guard_t;

  typedef enum logic [1:0] {
    N_IDLE, N_SEQ, N_LOOP
  } nxt_t;

  typedef enum logic [1:0] {
    L_NO, L_YES, L_LOOP
  } last_t;

  typedef struct packed {
    guard_t     guard;
    act_t       act;
    logic       emit;
    src_t       src;
    logic [1:0] rkind;
    last_t      last;
    nxt_t       nxt;
    upc_t       target;
  } ucode_t;

  typedef struct packed {
    logic fill_nz;
    logic room;
    logic out_free;
  } seq_stat_t;

  typedef struct packed {
    logic       idle;
    act_t       act;
    logic       emit;
    src_t       src;
    logic [1:0] rkind;
    logic       last;
    logic [4:0] cnt;
  } seq_ctl_t;

  function automatic ucode_t ucode_rom(upc_t addr);
    ucode_t w;
    w = '{G_ALWAYS, A_NONE, 1'b0, S_ZERO, RK_TX, L_NO, N_IDLE, U_IDLE};
    case (addr)
      U_ERR:   w = '{G_ALWAYS,   A_NONE,    1'b1, S_MSG,  RK_TX,     L_LOOP, N_LOOP, U_ERR};
      U_DEL0:  w = '{G_FILL_NZ,  A_NONE,    1'b1, S_BS,   RK_TX,     L_NO,   N_SEQ,  U_IDLE};
      U_DEL1:  w = '{G_ALWAYS,   A_NONE,    1'b1, S_SP,   RK_TX,     L_NO,   N_SEQ,  U_IDLE};
      U_DEL2:  w = '{G_ALWAYS,   A_DEL,     1'b1, S_BS,   RK_TX,     L_YES,  N_IDLE, U_IDLE};
      U_NL:    w = '{G_ALWAYS,   A_NL,      1'b1, S_CH,   RK_TX,     L_YES,  N_IDLE, U_IDLE};
      U_CHR:   w = '{G_ROOM,     A_STORE,   1'b1, S_CH,   RK_TX,     L_YES,  N_IDLE, U_IDLE};
      U_TAKE0: w = '{G_ALWAYS,   A_REWIND,  1'b0, S_ZERO, RK_LINE,   L_NO,   N_SEQ,  U_IDLE};
      U_TAKE1: w = '{G_CNT_LEFT, A_READ,    1'b0, S_ZERO, RK_LINE,   L_NO,   N_SEQ,  U_IDLE};
      U_TAKE2: w = '{G_ALWAYS,   A_NONE,    1'b1, S_MEM,  RK_LINE,   L_LOOP, N_LOOP, U_TAKE1};
      U_CLR:   w = '{G_ALWAYS,   A_CLR_RDY, 1'b1, S_ZERO, RK_STATUS, L_YES,  N_IDLE, U_IDLE};
      U_QRY:   w = '{G_ALWAYS,   A_NONE,    1'b1, S_ZERO, RK_STATUS, L_YES,  N_IDLE, U_IDLE};
      default: w = '{G_ALWAYS,   A_NONE,    1'b0, S_ZERO, RK_TX,     L_NO,   N_IDLE, U_IDLE};
    endcase
    return w;
  endfunction

  function automatic logic [7:0] msg_byte(logic [4:0] pos);
    logic [4:0] off;
    off = (MSG_LEN - 5'd1) - pos;
    return MSG_TEXT[{off, 3'b000} +: 8];
  endfunction

endpackage

@@ design/uled_seq.sv @@
// Microcode sequencer of the line editor: step counter, loop counter and jumps.
// Depends on uled_pkg for the control store and the control word types.
`timescale 1ns / 1ps

module uled_seq
  import uled_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  upc_t       entry,
  input  logic [4:0] limit,
  input  seq_stat_t  stat,
  output seq_ctl_t   ctl
);

  upc_t       upc_r, upc_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic [4:0] limit_r, limit_nxt;
  ucode_t     uc;
  logic       gok;
  logic       done;
  logic       fire;
  logic       run;

  always_comb begin
    uc   = ucode_rom(upc_r);
    done = ((cnt_r + 5'd1) == limit_r);
    case (uc.guard)
      G_ALWAYS:   gok = 1'b1;
      G_FILL_NZ:  gok = stat.fill_nz;
      G_ROOM:     gok = stat.room;
      G_CNT_LEFT: gok = (cnt_r != limit_r);
      default:    gok = 1'b1;
    endcase
    fire = (upc_r != U_IDLE) && (!(gok && uc.emit) || stat.out_free);
    run  = fire && gok;

    upc_nxt   = upc_r;
    cnt_nxt   = cnt_r;
    limit_nxt = limit_r;
    if (upc_r == U_IDLE) begin
      if (start) begin
        upc_nxt   = entry;
        cnt_nxt   = 5'd0;
        limit_nxt = limit;
      end
    end else if (fire) begin
      if (!gok) begin
        upc_nxt = U_IDLE;
      end else begin
        case (uc.nxt)
          N_IDLE:  upc_nxt = U_IDLE;
          N_SEQ:   upc_nxt = upc_t'(upc_r + 4'd1);
          N_LOOP:  upc_nxt = done ? U_IDLE : uc.target;
          default: upc_nxt = U_IDLE;
        endcase
        if (uc.last == L_LOOP) begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
    end

    ctl.idle  = (upc_r == U_IDLE);
    ctl.act   = run ? uc.act : A_NONE;
    ctl.emit  = run && uc.emit;
    ctl.src   = uc.src;
    ctl.rkind = uc.rkind;
    ctl.last  = (uc.last == L_YES) || ((uc.last == L_LOOP) && done);
    ctl.cnt   = cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r   <= U_IDLE;
      cnt_r   <= 5'd0;
      limit_r <= 5'd0;
    end else begin
      upc_r   <= upc_nxt;
      cnt_r   <= cnt_nxt;
      limit_r <= limit_nxt;
    end
  end

endmodule

@@ design/uart_line_editor_echo.sv @@
// Channel  Ports                                              Direction
// in       in_valid/in_ready, kind, rx_valid, rx_byte, count  item into the editor
// out      out_valid/out_ready, result_kind, byte, index      echo, line and status bytes
//
// An item is taken only when the sequencer is idle; the dispatch cycle picks a microprogram.
// Each result is emitted by its own step, a line byte by a memory read and then an emit:
// an invalid receive sends the 31-byte message, a take of n sends min(n, LINE_DEPTH) bytes.
// Reset clears the line valid bits, fill position, ready flag and the sequencer.
// A full output register with out_ready low holds the current step.
// Holds the datapath and line memory; depends on uled_pkg and uled_seq.
`timescale 1ns / 1ps

module uart_line_editor_echo
  import uled_pkg::*;
#(
  parameter int LINE_DEPTH = 5
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_kind,
  input  logic       in_rx_valid,
  input  logic [7:0] in_rx_byte,
  input  logic [2:0] in_take_count,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_result_kind,
  output logic [7:0] out_out_byte,
  output logic [2:0] out_line_index,
  output logic       out_input_ready,
  output logic       out_last
);

  localparam int AW = $clog2(LINE_DEPTH);

  logic [7:0]            mem [LINE_DEPTH];
  logic [LINE_DEPTH-1:0] vld_r, vld_nxt;
  logic [AW-1:0]         fill_r, fill_nxt;
  logic                  rdy_r, rdy_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [7:0]            ch_r;
  logic [7:0]            mem_rd_r;
  logic                  rd_vld_r;
  logic [1:0]            rkind_r;
  logic [7:0]            byte_r;
  logic [2:0]            index_r;
  logic                  iready_r;
  logic                  last_r;

  logic [7:0]    ch_up;
  logic          start;
  upc_t          entry;
  logic [4:0]    limit;
  logic [4:0]    take_lim;
  seq_stat_t     stat;
  seq_ctl_t      ctl;
  logic [AW-1:0] rd_idx;
  logic [7:0]    byte_mux;

  uled_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .entry (entry),
    .limit (limit),
    .stat  (stat),
    .ctl   (ctl)
  );

  always_comb begin
    in_ready = ctl.idle;
    start    = in_valid && ctl.idle;
    ch_up    = ((in_rx_byte >= CH_LOW_A) && (in_rx_byte <= CH_LOW_Z)) ?
               (in_rx_byte - CASE_OFFSET) : in_rx_byte;
    take_lim = (int'(in_take_count) > LINE_DEPTH) ? 5'(LINE_DEPTH) : {2'b00, in_take_count};

    case (in_kind)
      KIND_RX: begin
        if (!in_rx_valid) begin
          entry = U_ERR;
        end else if (ch_up == CH_DELETE) begin
          entry = U_DEL0;
        end else if (ch_up == CH_NEWLINE) begin
          entry = U_NL;
        end else begin
          entry = U_CHR;
        end
      end
      KIND_TAKE:  entry = U_TAKE0;
      KIND_CLEAR: entry = U_CLR;
      KIND_QUERY: entry = U_QRY;
      default:    entry = U_QRY;
    endcase
    limit = (in_kind == KIND_RX) ? MSG_LEN : take_lim;

    stat.fill_nz  = (fill_r != '0);
    stat.room     = (fill_r < AW'(LINE_DEPTH - 1));
    stat.out_free = !out_valid_r || out_ready;
    rd_idx        = AW'(ctl.cnt);

    vld_nxt  = vld_r;
    fill_nxt = fill_r;
    rdy_nxt  = rdy_r;
    case (ctl.act)
      A_STORE: begin
        if (fill_r == '0) begin
          vld_nxt = '0;
        end
        vld_nxt[fill_r] = 1'b1;
        fill_nxt        = fill_r + AW'(1);
      end
      A_DEL: begin
        vld_nxt[fill_r] = 1'b0;
        fill_nxt        = fill_r - AW'(1);
      end
      A_NL: begin
        vld_nxt[fill_r] = 1'b0;
        fill_nxt        = '0;
        rdy_nxt         = 1'b1;
      end
      A_REWIND:  fill_nxt = '0;
      A_CLR_RDY: rdy_nxt  = 1'b0;
      default: begin
      end
    endcase

    case (ctl.src)
      S_MSG:   byte_mux = msg_byte(ctl.cnt);
      S_BS:    byte_mux = CH_BS;
      S_SP:    byte_mux = CH_SP;
      S_CH:    byte_mux = ch_r;
      S_MEM:   byte_mux = rd_vld_r ? mem_rd_r : 8'h00;
      default: byte_mux = 8'h00;
    endcase

    if (ctl.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      fill_r      <= '0;
      rdy_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= vld_nxt;
      fill_r      <= fill_nxt;
      rdy_r       <= rdy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ch_r <= ch_up;
    end
    if (ctl.act == A_STORE) begin
      mem[fill_r] <= ch_r;
    end
    if (ctl.act == A_READ) begin
      mem_rd_r <= mem[rd_idx];
      rd_vld_r <= vld_r[rd_idx];
    end
    if (ctl.emit) begin
      rkind_r  <= ctl.rkind;
      byte_r   <= byte_mux;
      index_r  <= (ctl.src == S_MEM) ? ctl.cnt[2:0] : 3'd0;
      iready_r <= rdy_nxt;
      last_r   <= ctl.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = rkind_r;
  assign out_out_byte    = byte_r;
  assign out_line_index  = index_r;
  assign out_input_ready = iready_r;
  assign out_last        = last_r;

endmodule
